// ===== design/double_ended_queue_indexed_unit_defines.svh =====
// Assertion macros for the indexed double-ended queue unit
`ifndef DOUBLE_ENDED_QUEUE_INDEXED_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_INDEXED_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DQI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("dqi check failed");

// Implication with a fixed delay in cycles before the consequent
`define DQI_ASSERT_DELAY(lbl, ante, dly, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##dly (cons)) \
        else $error("dqi timing check failed");

`endif

// ===== design/dqi_pkg.sv =====
// Shared types and constants for the indexed double-ended queue unit
`timescale 1ns / 1ps
`default_nettype none

package dqi_pkg;

    localparam int CAPACITY   = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    localparam int FUNC_W  = 3;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int ERR_W   = 2;
    localparam int COUNT_W = 11;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT  = 3'd0,
        FN_PUSH_BACK   = 3'd1,
        FN_READ_INDEX  = 3'd2,
        FN_WRITE_INDEX = 3'd3,
        FN_READ_FRONT  = 3'd4,
        FN_READ_BACK   = 3'd5,
        FN_WRITE_FRONT = 3'd6,
        FN_WRITE_BACK  = 3'd7
    } t_func;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 2'd0,
        ERR_RANGE = 2'd1,
        ERR_FULL  = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

// ===== design/double_ended_queue_indexed_unit.sv =====
// Top level of the indexed double-ended queue unit
//
// Command port: drive i_func, i_index and i_value and raise start; the item
// transfers at a rising edge where start is high and busy is low.
// Functions push at the front or back, read or write the element at a
// logical index from the front, or read or write the front or back element.
// One result per item: after execute, o_strobe is high for exactly one cycle
// in the done state, with o_read_data, o_error, o_count and o_empty_res.
// The receiver cannot stall; results must be taken in that cycle.
// No item transfers while busy is high; a new item may transfer in the
// cycle that shows the previous result. The execute cycle holds the single
// port of the element store (one access per item) and updates head/count;
// the store's registered read delivers data in the following result cycle.
// Reset (i_rst_n low, synchronous) empties the queue and puts the head at
// slot zero; element storage is not cleared and needs no clearing pass.
// Errors: index at or past the count, or front/back access on an empty
// queue, give error 1; a push while full gives error 2; neither changes state.
`timescale 1ns / 1ps
`default_nettype none
`include "double_ended_queue_indexed_unit_defines.svh"

module double_ended_queue_indexed_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [dqi_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [dqi_pkg::INDEX_W-1:0]   i_index,
    input  wire logic [dqi_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_strobe,
    output logic      [dqi_pkg::VALUE_W-1:0]   o_read_data,
    output logic      [dqi_pkg::ERR_W-1:0]     o_error,
    output logic      [dqi_pkg::COUNT_W-1:0]   o_count,
    output logic                               o_empty_res
);

    dqi_pkg::t_cmd cmd;

    dqi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_strobe (o_strobe)
    );

    dqi_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_func      (i_func),
        .i_index     (i_index),
        .i_value     (i_value),
        .o_read_data (o_read_data),
        .o_error     (o_error),
        .o_count     (o_count),
        .o_empty_res (o_empty_res)
    );

    `DQI_ASSERT_DELAY(a_result_follows, start && !busy, 2, o_strobe)
    `DQI_ASSERT_IMPL(a_empty_matches, o_strobe, o_empty_res == (o_count == '0))
    `DQI_ASSERT_IMPL(a_err_zero_data, o_strobe && (o_error != dqi_pkg::ERR_OK), o_read_data == '0)
    `DQI_ASSERT_IMPL(a_count_bound, o_strobe, 32'(o_count) <= dqi_pkg::CAPACITY)

endmodule

`default_nettype wire

// ===== design/dqi_ram.sv =====
// Generic single-port RAM with registered read
`timescale 1ns / 1ps
`default_nettype none

module dqi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH)-1:0]         i_addr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    output logic      [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/dqi_ctrl.sv =====
// Sequencing state machine for the indexed double-ended queue unit
`timescale 1ns / 1ps
`default_nettype none

module dqi_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output dqi_pkg::t_cmd      o_cmd,
    output logic               o_busy,
    output logic               o_strobe
);

    dqi_pkg::t_state r_state;
    dqi_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dqi_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dqi_pkg::ST_IDLE: begin
                if (i_start) n_state = dqi_pkg::ST_EXEC;
            end
            dqi_pkg::ST_EXEC: begin
                n_state = dqi_pkg::ST_DONE;
            end
            dqi_pkg::ST_DONE: begin
                n_state = i_start ? dqi_pkg::ST_EXEC : dqi_pkg::ST_IDLE;
            end
            default: n_state = dqi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_busy     = 1'b0;
        o_strobe   = 1'b0;
        unique case (r_state)
            dqi_pkg::ST_IDLE: begin
                o_cmd.load = i_start;
            end
            dqi_pkg::ST_EXEC: begin
                o_cmd.exec = 1'b1;
                o_busy     = 1'b1;
            end
            dqi_pkg::ST_DONE: begin
                // result goes out while the next transfer may be taken
                o_strobe   = 1'b1;
                o_cmd.load = i_start;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/dqi_datapath.sv =====
// Pointer, count and element store datapath for the indexed double-ended queue unit
`timescale 1ns / 1ps
`default_nettype none

module dqi_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire dqi_pkg::t_cmd                 i_cmd,
    input  wire logic [dqi_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [dqi_pkg::INDEX_W-1:0]   i_index,
    input  wire logic [dqi_pkg::VALUE_W-1:0]   i_value,
    output logic      [dqi_pkg::VALUE_W-1:0]   o_read_data,
    output logic      [dqi_pkg::ERR_W-1:0]     o_error,
    output logic      [dqi_pkg::COUNT_W-1:0]   o_count,
    output logic                               o_empty_res
);

    localparam int AW = dqi_pkg::ADDR_W;
    localparam int CW = dqi_pkg::CNT_W;
    localparam logic [AW:0]   CAP_EXT  = (AW + 1)'(dqi_pkg::CAPACITY);
    localparam logic [CW-1:0] CAP_CNT  = CW'(dqi_pkg::CAPACITY);
    localparam logic [AW-1:0] LAST_POS = AW'(dqi_pkg::CAPACITY - 1);

    // captured item
    dqi_pkg::t_func                  r_func;
    logic [dqi_pkg::INDEX_W-1:0]     r_index;
    logic [dqi_pkg::VALUE_W-1:0]     r_value;

    // queue state
    logic [AW-1:0]  r_head;
    logic [AW-1:0]  n_head;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  n_count;

    // result state
    dqi_pkg::t_err  r_err;
    dqi_pkg::t_err  n_err;
    logic           r_rd_sel;
    logic           n_rd_sel;

    logic                            ram_we;
    logic [AW-1:0]                   ram_addr;
    logic [dqi_pkg::DATA_WIDTH-1:0]  ram_rdata;

    logic           full;
    logic           empty;
    logic           idx_bad;
    logic [AW-1:0]  head_dec;
    logic [AW-1:0]  pos;
    logic [AW:0]    slot_sum;
    logic [AW-1:0]  slot;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= dqi_pkg::t_func'(i_func);
            r_index <= i_index;
            r_value <= i_value;
        end
    end

    assign full     = (r_count == CAP_CNT);
    assign empty    = (r_count == '0);
    assign idx_bad  = (32'(r_index) >= 32'(r_count));
    assign head_dec = (r_head == '0) ? LAST_POS : (r_head - AW'(1));

    // logical position, then wrap onto the circular store
    always_comb begin
        unique case (r_func)
            dqi_pkg::FN_PUSH_BACK:                    pos = AW'(r_count);
            dqi_pkg::FN_READ_INDEX,
            dqi_pkg::FN_WRITE_INDEX:                  pos = AW'(r_index);
            dqi_pkg::FN_READ_BACK,
            dqi_pkg::FN_WRITE_BACK:                   pos = AW'(r_count - CW'(1));
            default:                                  pos = '0;
        endcase
    end

    assign slot_sum = {1'b0, r_head} + {1'b0, pos};
    assign slot     = (slot_sum >= CAP_EXT) ? AW'(slot_sum - CAP_EXT) : AW'(slot_sum);

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_err    = dqi_pkg::ERR_OK;
        n_rd_sel = 1'b0;
        ram_we   = 1'b0;
        ram_addr = slot;
        unique case (r_func)
            dqi_pkg::FN_PUSH_FRONT: begin
                ram_addr = head_dec;
                if (full) begin
                    n_err = dqi_pkg::ERR_FULL;
                end else begin
                    ram_we  = 1'b1;
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                end
            end
            dqi_pkg::FN_PUSH_BACK: begin
                if (full) begin
                    n_err = dqi_pkg::ERR_FULL;
                end else begin
                    ram_we  = 1'b1;
                    n_count = r_count + CW'(1);
                end
            end
            dqi_pkg::FN_READ_INDEX: begin
                if (idx_bad) n_err = dqi_pkg::ERR_RANGE;
                else         n_rd_sel = 1'b1;
            end
            dqi_pkg::FN_WRITE_INDEX: begin
                if (idx_bad) n_err = dqi_pkg::ERR_RANGE;
                else         ram_we = 1'b1;
            end
            dqi_pkg::FN_READ_FRONT,
            dqi_pkg::FN_READ_BACK: begin
                if (empty) n_err = dqi_pkg::ERR_RANGE;
                else       n_rd_sel = 1'b1;
            end
            dqi_pkg::FN_WRITE_FRONT,
            dqi_pkg::FN_WRITE_BACK: begin
                if (empty) n_err = dqi_pkg::ERR_RANGE;
                else       ram_we = 1'b1;
            end
            default: begin
                n_err = dqi_pkg::ERR_OK;
            end
        endcase
        // hold everything outside the execute cycle
        if (!i_cmd.exec) begin
            n_head   = r_head;
            n_count  = r_count;
            n_err    = r_err;
            n_rd_sel = r_rd_sel;
            ram_we   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_err    <= dqi_pkg::ERR_OK;
            r_rd_sel <= 1'b0;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_err    <= n_err;
            r_rd_sel <= n_rd_sel;
        end
    end

    dqi_ram #(
        .WIDTH (dqi_pkg::DATA_WIDTH),
        .DEPTH (dqi_pkg::CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (dqi_pkg::DATA_WIDTH'(r_value)),
        .o_rdata (ram_rdata)
    );

    assign o_read_data = r_rd_sel ? dqi_pkg::VALUE_W'(ram_rdata) : '0;
    assign o_error     = r_err;
    assign o_count     = dqi_pkg::COUNT_W'(r_count);
    assign o_empty_res = (r_count == '0);

endmodule

`default_nettype wire
